FILE: src/txtc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// txtc_pkg
// Shared types, constants, font table and mask helpers for the text console
// glyph renderer.
// ----------------------------------------------------------------------------
package txtc_pkg;

	localparam int MulAW = 16;
	localparam int MulBW = 16;
	localparam int AccW  = 28;

	localparam logic [7:0] CODE_NEWLINE = 8'd10;
	localparam logic [7:0] CODE_TAB     = 8'd9;

	localparam logic [2:0] MAX_SCALE = 3'd4;

	typedef enum logic [2:0] {
		REG_SCREEN_WIDTH  = 3'd0,
		REG_SCREEN_HEIGHT = 3'd1,
		REG_LINE_PITCH    = 3'd2,
		REG_GLYPH_SCALE   = 3'd3,
		REG_FG_COLOR      = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [MulAW-1:0] a;
		logic [MulBW-1:0] b;
		logic [AccW-1:0]  c;
	} mac_op_t;

	function automatic logic [63:0] r8(
		input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
		input logic [7:0] b3, input logic [7:0] b4, input logic [7:0] b5,
		input logic [7:0] b6, input logic [7:0] b7);
		r8 = {b7, b6, b5, b4, b3, b2, b1, b0};
	endfunction

	// row 0 in bits 7:0, bit 0 of each row is the leftmost pixel
	function automatic logic [63:0] font_glyph(input logic [6:0] code);
		logic [63:0] g;
		g = '0;
		case (code)
			7'h21: g = r8(8'h18,8'h3C,8'h3C,8'h18,8'h18,8'h00,8'h18,8'h00);
			7'h22: g = r8(8'h36,8'h36,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00);
			7'h23: g = r8(8'h36,8'h36,8'h7F,8'h36,8'h7F,8'h36,8'h36,8'h00);
			7'h24: g = r8(8'h0C,8'h3E,8'h03,8'h1E,8'h30,8'h1F,8'h0C,8'h00);
			7'h25: g = r8(8'h00,8'h63,8'h33,8'h18,8'h0C,8'h66,8'h63,8'h00);
			7'h26: g = r8(8'h1C,8'h36,8'h1C,8'h6E,8'h3B,8'h33,8'h6E,8'h00);
			7'h27: g = r8(8'h06,8'h06,8'h03,8'h00,8'h00,8'h00,8'h00,8'h00);
			7'h28: g = r8(8'h18,8'h0C,8'h06,8'h06,8'h06,8'h0C,8'h18,8'h00);
			7'h29: g = r8(8'h06,8'h0C,8'h18,8'h18,8'h18,8'h0C,8'h06,8'h00);
			7'h2A: g = r8(8'h00,8'h66,8'h3C,8'hFF,8'h3C,8'h66,8'h00,8'h00);
			7'h2B: g = r8(8'h00,8'h0C,8'h0C,8'h3F,8'h0C,8'h0C,8'h00,8'h00);
			7'h2C: g = r8(8'h00,8'h00,8'h00,8'h00,8'h00,8'h0C,8'h0C,8'h06);
			7'h2D: g = r8(8'h00,8'h00,8'h00,8'h3F,8'h00,8'h00,8'h00,8'h00);
			7'h2E: g = r8(8'h00,8'h00,8'h00,8'h00,8'h00,8'h0C,8'h0C,8'h00);
			7'h2F: g = r8(8'h60,8'h30,8'h18,8'h0C,8'h06,8'h03,8'h01,8'h00);
			7'h30: g = r8(8'h3E,8'h63,8'h73,8'h7B,8'h6F,8'h67,8'h3E,8'h00);
			7'h31: g = r8(8'h0C,8'h0E,8'h0C,8'h0C,8'h0C,8'h0C,8'h3F,8'h00);
			7'h32: g = r8(8'h1E,8'h33,8'h30,8'h1C,8'h06,8'h33,8'h3F,8'h00);
			7'h33: g = r8(8'h1E,8'h33,8'h30,8'h1C,8'h30,8'h33,8'h1E,8'h00);
			7'h34: g = r8(8'h38,8'h3C,8'h36,8'h33,8'h7F,8'h30,8'h78,8'h00);
			7'h35: g = r8(8'h3F,8'h03,8'h1F,8'h30,8'h30,8'h33,8'h1E,8'h00);
			7'h36: g = r8(8'h1C,8'h06,8'h03,8'h1F,8'h33,8'h33,8'h1E,8'h00);
			7'h37: g = r8(8'h3F,8'h33,8'h30,8'h18,8'h0C,8'h0C,8'h0C,8'h00);
			7'h38: g = r8(8'h1E,8'h33,8'h33,8'h1E,8'h33,8'h33,8'h1E,8'h00);
			7'h39: g = r8(8'h1E,8'h33,8'h33,8'h3E,8'h30,8'h18,8'h0E,8'h00);
			7'h3A: g = r8(8'h00,8'h0C,8'h0C,8'h00,8'h00,8'h0C,8'h0C,8'h00);
			7'h3B: g = r8(8'h00,8'h0C,8'h0C,8'h00,8'h00,8'h0C,8'h0C,8'h06);
			7'h3C: g = r8(8'h18,8'h0C,8'h06,8'h03,8'h06,8'h0C,8'h18,8'h00);
			7'h3D: g = r8(8'h00,8'h00,8'h3F,8'h00,8'h00,8'h3F,8'h00,8'h00);
			7'h3E: g = r8(8'h06,8'h0C,8'h18,8'h30,8'h18,8'h0C,8'h06,8'h00);
			7'h3F: g = r8(8'h1E,8'h33,8'h30,8'h18,8'h0C,8'h00,8'h0C,8'h00);
			7'h40: g = r8(8'h3E,8'h63,8'h7B,8'h7B,8'h7B,8'h03,8'h1E,8'h00);
			7'h41: g = r8(8'h0C,8'h1E,8'h33,8'h33,8'h3F,8'h33,8'h33,8'h00);
			7'h42: g = r8(8'h3F,8'h66,8'h66,8'h3E,8'h66,8'h66,8'h3F,8'h00);
			7'h43: g = r8(8'h3C,8'h66,8'h03,8'h03,8'h03,8'h66,8'h3C,8'h00);
			7'h44: g = r8(8'h1F,8'h36,8'h66,8'h66,8'h66,8'h36,8'h1F,8'h00);
			7'h45: g = r8(8'h7F,8'h46,8'h16,8'h1E,8'h16,8'h46,8'h7F,8'h00);
			7'h46: g = r8(8'h7F,8'h46,8'h16,8'h1E,8'h16,8'h06,8'h0F,8'h00);
			7'h47: g = r8(8'h3C,8'h66,8'h03,8'h03,8'h73,8'h66,8'h7C,8'h00);
			7'h48: g = r8(8'h33,8'h33,8'h33,8'h3F,8'h33,8'h33,8'h33,8'h00);
			7'h49: g = r8(8'h1E,8'h0C,8'h0C,8'h0C,8'h0C,8'h0C,8'h1E,8'h00);
			7'h4A: g = r8(8'h78,8'h30,8'h30,8'h30,8'h33,8'h33,8'h1E,8'h00);
			7'h4B: g = r8(8'h67,8'h66,8'h36,8'h1E,8'h36,8'h66,8'h67,8'h00);
			7'h4C: g = r8(8'h0F,8'h06,8'h06,8'h06,8'h46,8'h66,8'h7F,8'h00);
			7'h4D: g = r8(8'h63,8'h77,8'h7F,8'h7F,8'h6B,8'h63,8'h63,8'h00);
			7'h4E: g = r8(8'h63,8'h67,8'h6F,8'h7B,8'h73,8'h63,8'h63,8'h00);
			7'h4F: g = r8(8'h1C,8'h36,8'h63,8'h63,8'h63,8'h36,8'h1C,8'h00);
			7'h50: g = r8(8'h3F,8'h66,8'h66,8'h3E,8'h06,8'h06,8'h0F,8'h00);
			7'h51: g = r8(8'h1E,8'h33,8'h33,8'h33,8'h3B,8'h1E,8'h38,8'h00);
			7'h52: g = r8(8'h3F,8'h66,8'h66,8'h3E,8'h36,8'h66,8'h67,8'h00);
			7'h53: g = r8(8'h1E,8'h33,8'h07,8'h0E,8'h38,8'h33,8'h1E,8'h00);
			7'h54: g = r8(8'h3F,8'h2D,8'h0C,8'h0C,8'h0C,8'h0C,8'h1E,8'h00);
			7'h55: g = r8(8'h33,8'h33,8'h33,8'h33,8'h33,8'h33,8'h3F,8'h00);
			7'h56: g = r8(8'h33,8'h33,8'h33,8'h33,8'h33,8'h1E,8'h0C,8'h00);
			7'h57: g = r8(8'h63,8'h63,8'h63,8'h6B,8'h7F,8'h77,8'h63,8'h00);
			7'h58: g = r8(8'h63,8'h63,8'h36,8'h1C,8'h1C,8'h36,8'h63,8'h00);
			7'h59: g = r8(8'h33,8'h33,8'h33,8'h1E,8'h0C,8'h0C,8'h1E,8'h00);
			7'h5A: g = r8(8'h7F,8'h63,8'h31,8'h18,8'h4C,8'h66,8'h7F,8'h00);
			7'h5B: g = r8(8'h1E,8'h06,8'h06,8'h06,8'h06,8'h06,8'h1E,8'h00);
			7'h5C: g = r8(8'h03,8'h06,8'h0C,8'h18,8'h30,8'h60,8'h40,8'h00);
			7'h5D: g = r8(8'h1E,8'h18,8'h18,8'h18,8'h18,8'h18,8'h1E,8'h00);
			7'h5E: g = r8(8'h08,8'h1C,8'h36,8'h63,8'h00,8'h00,8'h00,8'h00);
			7'h5F: g = r8(8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'hFF);
			7'h60: g = r8(8'h0C,8'h0C,8'h18,8'h00,8'h00,8'h00,8'h00,8'h00);
			7'h61: g = r8(8'h00,8'h00,8'h1E,8'h30,8'h3E,8'h33,8'h6E,8'h00);
			7'h62: g = r8(8'h07,8'h06,8'h06,8'h3E,8'h66,8'h66,8'h3B,8'h00);
			7'h63: g = r8(8'h00,8'h00,8'h1E,8'h33,8'h03,8'h33,8'h1E,8'h00);
			7'h64: g = r8(8'h38,8'h30,8'h30,8'h3E,8'h33,8'h33,8'h6E,8'h00);
			7'h65: g = r8(8'h00,8'h00,8'h1E,8'h33,8'h3F,8'h03,8'h1E,8'h00);
			7'h66: g = r8(8'h1C,8'h36,8'h06,8'h0F,8'h06,8'h06,8'h0F,8'h00);
			7'h67: g = r8(8'h00,8'h00,8'h6E,8'h33,8'h33,8'h3E,8'h30,8'h1F);
			7'h68: g = r8(8'h07,8'h06,8'h36,8'h6E,8'h66,8'h66,8'h67,8'h00);
			7'h69: g = r8(8'h0C,8'h00,8'h0E,8'h0C,8'h0C,8'h0C,8'h1E,8'h00);
			7'h6A: g = r8(8'h30,8'h00,8'h30,8'h30,8'h30,8'h33,8'h33,8'h1E);
			7'h6B: g = r8(8'h07,8'h06,8'h66,8'h36,8'h1E,8'h36,8'h67,8'h00);
			7'h6C: g = r8(8'h0E,8'h0C,8'h0C,8'h0C,8'h0C,8'h0C,8'h1E,8'h00);
			7'h6D: g = r8(8'h00,8'h00,8'h33,8'h7F,8'h7F,8'h6B,8'h63,8'h00);
			7'h6E: g = r8(8'h00,8'h00,8'h1F,8'h33,8'h33,8'h33,8'h33,8'h00);
			7'h6F: g = r8(8'h00,8'h00,8'h1E,8'h33,8'h33,8'h33,8'h1E,8'h00);
			7'h70: g = r8(8'h00,8'h00,8'h3B,8'h66,8'h66,8'h3E,8'h06,8'h0F);
			7'h71: g = r8(8'h00,8'h00,8'h6E,8'h33,8'h33,8'h3E,8'h30,8'h78);
			7'h72: g = r8(8'h00,8'h00,8'h3B,8'h6E,8'h66,8'h06,8'h0F,8'h00);
			7'h73: g = r8(8'h00,8'h00,8'h3E,8'h03,8'h1E,8'h30,8'h1F,8'h00);
			7'h74: g = r8(8'h08,8'h0C,8'h3E,8'h0C,8'h0C,8'h2C,8'h18,8'h00);
			7'h75: g = r8(8'h00,8'h00,8'h33,8'h33,8'h33,8'h33,8'h6E,8'h00);
			7'h76: g = r8(8'h00,8'h00,8'h33,8'h33,8'h33,8'h1E,8'h0C,8'h00);
			7'h77: g = r8(8'h00,8'h00,8'h63,8'h6B,8'h7F,8'h7F,8'h36,8'h00);
			7'h78: g = r8(8'h00,8'h00,8'h63,8'h36,8'h1C,8'h36,8'h63,8'h00);
			7'h79: g = r8(8'h00,8'h00,8'h33,8'h33,8'h33,8'h3E,8'h30,8'h1F);
			7'h7A: g = r8(8'h00,8'h00,8'h3F,8'h19,8'h0C,8'h26,8'h3F,8'h00);
			7'h7B: g = r8(8'h38,8'h0C,8'h0C,8'h07,8'h0C,8'h0C,8'h38,8'h00);
			7'h7C: g = r8(8'h18,8'h18,8'h18,8'h00,8'h18,8'h18,8'h18,8'h00);
			7'h7D: g = r8(8'h07,8'h0C,8'h0C,8'h38,8'h0C,8'h0C,8'h07,8'h00);
			7'h7E: g = r8(8'h6E,8'h3B,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00);
			default: g = '0;
		endcase
		return g;
	endfunction

	// clamp the scale register to 1..MAX_SCALE
	function automatic logic [2:0] eff_scale(input logic [2:0] s);
		logic [2:0] r;
		r = s;
		if (s == 3'd0)
			r = 3'd1;
		else if (s > MAX_SCALE)
			r = MAX_SCALE;
		return r;
	endfunction

	// horizontal magnification of one font row
	function automatic logic [31:0] expand_row(input logic [7:0] bits, input logic [2:0] s);
		logic [31:0] m;
		m = '0;
		case (s)
			3'd2: for (int x = 0; x < 16; x++) m[x] = bits[x / 2];
			3'd3: for (int x = 0; x < 24; x++) m[x] = bits[x / 3];
			3'd4: for (int x = 0; x < 32; x++) m[x] = bits[x / 4];
			default: m[7:0] = bits;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

FILE: src/txtc_mac.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// txtc_mac
// Shared multiply-accumulate unit: res = a * b + c, truncated to the
// accumulator width.
// ----------------------------------------------------------------------------
module txtc_mac
	import txtc_pkg::*;
(
	input  mac_op_t         op,
	output logic [AccW-1:0] res
);

	logic [MulAW+MulBW-1:0] prod;

	assign prod = op.a * op.b;
	assign res  = prod[AccW-1:0] + op.c;

endmodule
`default_nettype wire

FILE: src/text_console_glyph_renderer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_glyph_renderer
// Text console cursor and 8x8 glyph rasterizer producing framebuffer row writes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one char_code per item. Newline
//   and tab only move the cursor. Any other code is drawn.
//   Output channel out_valid/out_ready carries one result per item: a clear
//   command (is_clear) when the cursor falls off the bottom, then 8*scale
//   glyph row writes, the final one flagged by last.
//   A drawn code is accepted in idle, then goes through the setup steps (wrap
//   check, row check, x offset, base offset, all on one shared multiply-add
//   unit), then emits one glyph row result per cycle unless the output stalls.
//   The input is not ready while a code is being drawn.
//   A single output register holds the current result while the receiver
//   stalls; the sequencer waits for it to drain before loading the next.
//   Reset homes the cursor and loads the default geometry (640x480, pitch
//   2560, scale 1, green). Write the cfg registers only while idle.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer
	import txtc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [23:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  char_code,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             is_clear,
	output logic [27:0]      byte_offset,
	output logic [31:0]      pixel_mask,
	output logic [23:0]      pixel_color,
	output logic             last
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_WRAP   = 6'b000010,
		S_ROWCHK = 6'b000100,
		S_XOFF   = 6'b001000,
		S_BASE   = 6'b010000,
		S_EMIT   = 6'b100000
	} state_t;

	state_t           state_q;
	logic [12:0]      width_q;
	logic [12:0]      height_q;
	logic [15:0]      pitch_q;
	logic [2:0]       scale_cfg_q;
	logic [23:0]      color_q;
	logic [8:0]       col_q;
	logic [8:0]       row_q;
	logic [63:0]      glyph_q;
	logic [2:0]       scale_q;
	logic [14:0]      start_y_q;
	logic [15:0]      xoff_q;
	logic [AccW-1:0]  offset_q;
	logic [2:0]       frow_q;
	logic [1:0]       sub_q;
	logic             out_valid_q;
	logic             clear_q;
	logic [27:0]      offset_out_q;
	logic [31:0]      mask_q;
	logic [23:0]      color_out_q;
	logic             last_q;

	mac_op_t          mac_op;
	logic [AccW-1:0]  mac_res;
	logic             out_free;
	logic             out_load;
	logic             in_fire;
	logic             sub_end;
	logic             row_last;
	logic [7:0]       row_bits;
	logic             do_wrap;
	logic             do_clear;

	txtc_mac u_mac (
		.op  (mac_op),
		.res (mac_res)
	);

	assign out_free = !out_valid_q || out_ready;
	assign out_load = out_free && ((state_q == S_ROWCHK && do_clear) || state_q == S_EMIT);
	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign sub_end  = ({1'b0, sub_q} + 3'd1) == scale_q;
	assign row_last = (frow_q == 3'd7) && sub_end;
	assign row_bits = glyph_q[{frow_q, 3'b000} +: 8];
	assign do_wrap  = mac_res >= {15'd0, width_q};
	assign do_clear = mac_res >= {15'd0, height_q};

	always_comb begin
		mac_op = '0;
		unique case (state_q)
			S_WRAP: begin
				mac_op.a = {6'd0, {1'b0, col_q} + 10'd1};
				mac_op.b = {10'd0, scale_q, 3'b000};
			end
			S_ROWCHK: begin
				mac_op.a = {7'd0, row_q};
				mac_op.b = {10'd0, {scale_q, 3'b000} + {1'b0, scale_q, 2'b00}};
			end
			S_XOFF: begin
				mac_op.a = {7'd0, col_q};
				mac_op.b = {8'd0, scale_q, 5'b00000};
			end
			S_BASE: begin
				mac_op.a = {1'b0, start_y_q};
				mac_op.b = pitch_q;
				mac_op.c = {12'd0, xoff_q};
			end
			S_EMIT: begin
				mac_op.a = pitch_q;
				mac_op.b = 16'd1;
				mac_op.c = offset_q;
			end
			default: mac_op = '0;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= 13'd640;
			height_q    <= 13'd480;
			pitch_q     <= 16'd2560;
			scale_cfg_q <= 3'd1;
			color_q     <= 24'h00FF00;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCREEN_WIDTH:  width_q     <= cfg_data[12:0];
				REG_SCREEN_HEIGHT: height_q    <= cfg_data[12:0];
				REG_LINE_PITCH:    pitch_q     <= cfg_data[15:0];
				REG_GLYPH_SCALE:   scale_cfg_q <= cfg_data[2:0];
				REG_FG_COLOR:      color_q     <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (char_code == CODE_NEWLINE) begin
							col_q <= '0;
							row_q <= row_q + 9'd1;
						end else if (char_code == CODE_TAB) begin
							col_q <= {col_q[8:2] + 7'd1, 2'b00};
						end else begin
							state_q <= S_WRAP;
						end
					end
				end
				S_WRAP: begin
					if (do_wrap) begin
						col_q <= '0;
						row_q <= row_q + 9'd1;
					end
					state_q <= S_ROWCHK;
				end
				S_ROWCHK: begin
					if (out_free) begin
						if (do_clear) begin
							col_q <= '0;
							row_q <= '0;
						end
						state_q <= S_XOFF;
					end
				end
				S_XOFF: state_q <= S_BASE;
				S_BASE: state_q <= S_EMIT;
				S_EMIT: begin
					if (out_free) begin
						if (row_last) begin
							col_q   <= col_q + 9'd1;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				glyph_q <= char_code[7] ? 64'd0 : font_glyph(char_code[6:0]);
				scale_q <= eff_scale(scale_cfg_q);
			end
			S_ROWCHK: begin
				if (out_free) begin
					if (do_clear) begin
						start_y_q    <= '0;
						clear_q      <= 1'b1;
						offset_out_q <= '0;
						mask_q       <= '0;
						color_out_q  <= '0;
						last_q       <= 1'b0;
					end else begin
						start_y_q <= mac_res[14:0];
					end
				end
			end
			S_XOFF: xoff_q <= mac_res[15:0];
			S_BASE: begin
				offset_q <= mac_res;
				frow_q   <= '0;
				sub_q    <= '0;
			end
			S_EMIT: begin
				if (out_free) begin
					clear_q      <= 1'b0;
					offset_out_q <= offset_q;
					mask_q       <= expand_row(row_bits, scale_q);
					color_out_q  <= color_q;
					last_q       <= row_last;
					offset_q     <= mac_res;
					if (sub_end) begin
						sub_q  <= '0;
						frow_q <= frow_q + 3'd1;
					end else begin
						sub_q <= sub_q + 2'd1;
					end
				end
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign is_clear    = clear_q;
	assign byte_offset = offset_out_q;
	assign pixel_mask  = mask_q;
	assign pixel_color = color_out_q;
	assign last        = last_q;

	a_clear_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_clear) |-> (byte_offset == 28'd0 && pixel_mask == 32'd0 && !last))
		else $error("clear result carries nonzero fields");

	a_clear_homes_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROWCHK && out_free && do_clear) |=> (col_q == 9'd0 && row_q == 9'd0))
		else $error("cursor not homed after clear");

	a_sub_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> ({1'b0, sub_q} < scale_q))
		else $error("scale sub-row counter out of range");

	a_mask_width: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_free && scale_q == 3'd1) |=> (pixel_mask[31:8] == 24'd0))
		else $error("mask wider than scaled glyph");

endmodule
`default_nettype wire
